// ===== rtl/rrsi_pkg.sv =====
// Shared widths, limits and face codes for the ray/rectangle slab test.
`timescale 1ns / 1ps
`default_nettype none
package rrsi_pkg;

   localparam int COORD_FRAC_BITS = 8;
   localparam int TIME_FRAC_BITS  = 16;

   localparam int CRD_W  = 24;                  // Q16.8 coordinates and Q8.16 time
   localparam int RECT_W = 16;
   localparam int EXT_W  = 15;
   localparam int OFS_W  = RECT_W + COORD_FRAC_BITS + 2;   // edge offset, signed
   localparam int DEN_W  = CRD_W;               // |dir|, unsigned
   localparam int PRD_W  = OFS_W + DEN_W + 1;   // signed cross products
   localparam int DIV_NW = OFS_W - 1 + DEN_W;   // dividend magnitude
   localparam int QUO_W  = CRD_W + 2;           // quotient bits before saturation
   localparam int DIV_LAT = QUO_W + 1;          // divider register stages
   localparam int NRM_W  = 3;

   localparam int REQ_W = 160;
   localparam int RSP_W = 80;

   localparam logic signed [CRD_W-1:0] OUT_MAX = {1'b0, {(CRD_W-1){1'b1}}};
   localparam logic signed [CRD_W-1:0] OUT_MIN = {1'b1, {(CRD_W-1){1'b0}}};

   typedef enum logic [NRM_W-1:0] {
      NRM_NONE  = 3'd0,
      NRM_LEFT  = 3'd1,
      NRM_RIGHT = 3'd2,
      NRM_UP    = 3'd3,
      NRM_DOWN  = 3'd4
   } normal_type;

endpackage
`default_nettype wire

// ===== rtl/rrsi_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
`timescale 1ns / 1ps
`default_nettype none
module rrsi_div (
   input  wire logic                         clock,
   input  wire logic                         enable,
   input  wire logic [rrsi_pkg::DIV_NW-1:0]  dividend,
   input  wire logic [rrsi_pkg::DEN_W-1:0]   divisor,
   output logic      [rrsi_pkg::QUO_W-1:0]   quotient,
   output logic                              overflow
);
   import rrsi_pkg::*;

   logic [DIV_NW-1:0] rem_ff [0:QUO_W-1];
   logic [DEN_W-1:0]  den_ff [0:QUO_W-1];
   logic [QUO_W-1:0]  quo_ff [0:QUO_W];
   logic              ovf_ff [0:QUO_W];

   // flag quotients that do not fit in QUO_W bits
   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff[0] <= dividend;
         den_ff[0] <= divisor;
         quo_ff[0] <= '0;
         ovf_ff[0] <= (dividend >> QUO_W) >= DIV_NW'(divisor);
      end
   end

   for (genvar k = 1; k <= QUO_W; k++) begin : g_stage
      localparam int B = QUO_W - k;
      logic [DIV_NW-1:0] sh;
      logic              ge;
      logic [QUO_W-1:0]  qn;

      always_comb begin
         sh    = DIV_NW'(den_ff[k-1]) << B;
         ge    = rem_ff[k-1] >= sh;
         qn    = quo_ff[k-1];
         qn[B] = ge;
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            quo_ff[k] <= qn;
            ovf_ff[k] <= ovf_ff[k-1];
         end
      end

      if (k < QUO_W) begin : g_rem
         always_ff @(posedge clock) begin
            if (enable) begin
               rem_ff[k] <= ge ? rem_ff[k-1] - sh : rem_ff[k-1];
               den_ff[k] <= den_ff[k-1];
            end
         end
      end
   end

   assign quotient = quo_ff[QUO_W];
   assign overflow = ovf_ff[QUO_W];

endmodule
`default_nettype wire

// ===== rtl/ray_rect_slab_intersect.sv =====
// Top level: 2D ray segment against rectangle, slab method, pipelined.
//
//  channel | dir | tdata bits (lowest first)
//  req_    | in  | origin_x 24, origin_y 24, dir_x 24, dir_y 24, rect_left 16,
//          |     | rect_top 16, rect_width 15, rect_height 15, 2 zero bits
//  rsp_    | out | hit 1, contact_time 24, contact_x 24, contact_y 24,
//          |     | normal_code 3, 4 zero bits
//
// One transfer in and one out per cycle while the output is not stalled. The pipeline
// holds 26-bit restoring dividers (input register plus one quotient bit per stage).
// Synchronous reset clears only the valid bits.
// A stalled output freezes every stage at once; nothing is dropped or repeated.
`timescale 1ns / 1ps
`default_nettype none
module ray_rect_slab_intersect (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_tvalid,
   output logic                             req_tready,
   // origin_x, origin_y, dir_x, dir_y, rect_left, rect_top, rect_width, rect_height
   input  wire logic [rrsi_pkg::REQ_W-1:0]  req_tdata,
   output logic                             rsp_tvalid,
   input  wire logic                        rsp_tready,
   // hit, contact_time, contact_x, contact_y, normal_code
   output logic      [rrsi_pkg::RSP_W-1:0]  rsp_tdata
);
   import rrsi_pkg::*;

   typedef struct packed {
      logic                   inf;
      logic signed [OFS_W-1:0] num;
   } tm_type;

   typedef struct packed {
      logic signed [CRD_W-1:0] ox;
      logic signed [CRD_W-1:0] oy;
      logic signed [CRD_W-1:0] dx;
      logic signed [CRD_W-1:0] dy;
      logic [DEN_W-1:0]        dxd;
      logic [DEN_W-1:0]        dyd;
      logic                    early;
   } base_type;

   typedef struct packed {
      logic                    vld;
      base_type                b;
      logic signed [OFS_W-1:0] nxn, fxn, nyn, fyn;
   } s1_type;

   typedef struct packed {
      logic     vld;
      base_type b;
      tm_type   nx, fx, ny, fy;
   } s2_type;

   typedef struct packed {
      logic                    vld;
      base_type                b;
      tm_type                  nx, fx, ny, fy;
      logic signed [PRD_W-1:0] p_nx_dy, p_fx_dy, p_ny_dx, p_fy_dx;
   } s4_type;

   typedef struct packed {
      logic     vld;
      base_type b;
      tm_type   nx, fx, ny, fy;
      logic     g_nx_fy, g_ny_fx, g_nx_ny, g_ny_nx, g_fy_fx;
   } s5_type;

   typedef struct packed {
      logic                    vld;
      logic                    hit;
      logic                    einf;
      logic signed [OFS_W-1:0] enm;
      logic [DEN_W-1:0]        eden;
      normal_type              normal;
      logic signed [CRD_W-1:0] ox, oy, dx, dy;
   } s6_type;

   typedef struct packed {
      logic                    vld;
      logic                    hit;
      logic                    einf;
      logic signed [OFS_W-1:0] enm;
      logic [DEN_W-1:0]        eden;
      normal_type              normal;
      logic signed [CRD_W-1:0] ox, oy;
      logic signed [PRD_W-1:0] px, py;
   } s7_type;

   typedef struct packed {
      logic                    vld;
      logic                    hit;
      logic                    einf;
      logic                    ct_neg, cx_neg, cy_neg;
      normal_type              normal;
      logic signed [CRD_W-1:0] ox, oy;
   } side_type;

   typedef struct packed {
      logic                    vld;
      logic                    hit;
      logic                    einf;
      logic signed [CRD_W-1:0] ct;
      logic signed [QUO_W:0]   qx, qy;
      logic                    ovx, ovy, nx, ny;
      normal_type              normal;
      logic signed [CRD_W-1:0] ox, oy;
   } f1_type;

   function automatic tm_type make_time(input logic signed [OFS_W-1:0] n,
                                        input logic dneg, input logic dzero);
      tm_type t;
      t.inf = dzero;
      if (dzero) begin
         t.num = (n > 0) ? OFS_W'(1) : -OFS_W'(1);
      end else begin
         t.num = dneg ? -n : n;
      end
      return t;
   endfunction

   // exact a > b given a.num*b.den (l) and b.num*a.den (r)
   function automatic logic time_gt(input tm_type a, input tm_type b,
                                    input logic signed [PRD_W-1:0] l,
                                    input logic signed [PRD_W-1:0] r);
      logic res;
      if (a.inf && b.inf) begin
         res = !a.num[OFS_W-1] && b.num[OFS_W-1];
      end else if (a.inf) begin
         res = !a.num[OFS_W-1];
      end else if (b.inf) begin
         res = b.num[OFS_W-1];
      end else begin
         res = l > r;
      end
      return res;
   endfunction

   function automatic logic same_gt(input tm_type a, input tm_type b);
      logic res;
      if (a.inf && b.inf) begin
         res = !a.num[OFS_W-1] && b.num[OFS_W-1];
      end else begin
         res = a.num > b.num;
      end
      return res;
   endfunction

   function automatic logic signed [CRD_W-1:0] sat_sum(
      input logic signed [QUO_W+1:0] s);
      logic signed [CRD_W-1:0] res;
      if (s > (QUO_W+2)'(OUT_MAX)) begin
         res = OUT_MAX;
      end else if (s < (QUO_W+2)'(OUT_MIN)) begin
         res = OUT_MIN;
      end else begin
         res = s[CRD_W-1:0];
      end
      return res;
   endfunction

   logic      adv;
   s1_type    s1_in, s1_ff;
   s2_type    s2_in, s2_ff;
   s2_type    s3_in, s3_ff;
   s4_type    s4_in, s4_ff;
   s5_type    s5_in, s5_ff;
   s6_type    s6_in, s6_ff;
   s7_type    s7_in, s7_ff;
   side_type  side_in;
   side_type  side_ff [0:DIV_LAT-1];
   logic [DIV_NW-1:0] nd_ct_in, nd_cx_in, nd_cy_in;
   logic [DEN_W-1:0]  den_in;
   logic [QUO_W-1:0]  q_ct, q_cx, q_cy;
   logic              o_ct, o_cx, o_cy;
   f1_type    f1_in, f1_ff;
   logic                    rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_W-1:0]        rsp_tdata_ff, rsp_tdata_in;

   // stall every stage while the output holds an untaken result
   assign adv        = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = adv;

   // stage 1: edge offsets, direction magnitudes, 0/0 check
   always_comb begin
      logic signed [RECT_W-1:0] rl, rt;
      logic [EXT_W-1:0]         rw, rh;
      rl = req_tdata[111:96];
      rt = req_tdata[127:112];
      rw = req_tdata[142:128];
      rh = req_tdata[157:143];
      s1_in.vld  = req_tvalid;
      s1_in.b.ox = req_tdata[23:0];
      s1_in.b.oy = req_tdata[47:24];
      s1_in.b.dx = req_tdata[71:48];
      s1_in.b.dy = req_tdata[95:72];
      s1_in.nxn  = (OFS_W'(rl) <<< COORD_FRAC_BITS) - OFS_W'(s1_in.b.ox);
      s1_in.fxn  = ((OFS_W'(rl) + OFS_W'(rw)) <<< COORD_FRAC_BITS) - OFS_W'(s1_in.b.ox);
      s1_in.nyn  = (OFS_W'(rt) <<< COORD_FRAC_BITS) - OFS_W'(s1_in.b.oy);
      s1_in.fyn  = ((OFS_W'(rt) + OFS_W'(rh)) <<< COORD_FRAC_BITS) - OFS_W'(s1_in.b.oy);
      s1_in.b.dxd = s1_in.b.dx[CRD_W-1] ? DEN_W'(-s1_in.b.dx) : DEN_W'(s1_in.b.dx);
      s1_in.b.dyd = s1_in.b.dy[CRD_W-1] ? DEN_W'(-s1_in.b.dy) : DEN_W'(s1_in.b.dy);
      s1_in.b.early = (s1_in.b.dx == '0 && (s1_in.nxn == '0 || s1_in.fxn == '0)) ||
                      (s1_in.b.dy == '0 && (s1_in.nyn == '0 || s1_in.fyn == '0));
   end

   // stage 2: signed times, infinities for zero direction
   always_comb begin
      s2_in.vld = s1_ff.vld;
      s2_in.b   = s1_ff.b;
      s2_in.nx  = make_time(s1_ff.nxn, s1_ff.b.dx[CRD_W-1], s1_ff.b.dx == '0);
      s2_in.fx  = make_time(s1_ff.fxn, s1_ff.b.dx[CRD_W-1], s1_ff.b.dx == '0);
      s2_in.ny  = make_time(s1_ff.nyn, s1_ff.b.dy[CRD_W-1], s1_ff.b.dy == '0);
      s2_in.fy  = make_time(s1_ff.fyn, s1_ff.b.dy[CRD_W-1], s1_ff.b.dy == '0);
   end

   // stage 3: order near and far per axis (same denominator)
   always_comb begin
      s3_in = s2_ff;
      if (same_gt(s2_ff.nx, s2_ff.fx)) begin
         s3_in.nx = s2_ff.fx;
         s3_in.fx = s2_ff.nx;
      end
      if (same_gt(s2_ff.ny, s2_ff.fy)) begin
         s3_in.ny = s2_ff.fy;
         s3_in.fy = s2_ff.ny;
      end
   end

   // stage 4: cross products for the exact compares
   always_comb begin
      s4_in.vld = s3_ff.vld;
      s4_in.b   = s3_ff.b;
      s4_in.nx  = s3_ff.nx;
      s4_in.fx  = s3_ff.fx;
      s4_in.ny  = s3_ff.ny;
      s4_in.fy  = s3_ff.fy;
      s4_in.p_nx_dy = s3_ff.nx.num * $signed({1'b0, s3_ff.b.dyd});
      s4_in.p_fx_dy = s3_ff.fx.num * $signed({1'b0, s3_ff.b.dyd});
      s4_in.p_ny_dx = s3_ff.ny.num * $signed({1'b0, s3_ff.b.dxd});
      s4_in.p_fy_dx = s3_ff.fy.num * $signed({1'b0, s3_ff.b.dxd});
   end

   // stage 5: compare flags
   always_comb begin
      s5_in.vld = s4_ff.vld;
      s5_in.b   = s4_ff.b;
      s5_in.nx  = s4_ff.nx;
      s5_in.fx  = s4_ff.fx;
      s5_in.ny  = s4_ff.ny;
      s5_in.fy  = s4_ff.fy;
      s5_in.g_nx_fy = time_gt(s4_ff.nx, s4_ff.fy, s4_ff.p_nx_dy, s4_ff.p_fy_dx);
      s5_in.g_ny_fx = time_gt(s4_ff.ny, s4_ff.fx, s4_ff.p_ny_dx, s4_ff.p_fx_dy);
      s5_in.g_nx_ny = time_gt(s4_ff.nx, s4_ff.ny, s4_ff.p_nx_dy, s4_ff.p_ny_dx);
      s5_in.g_ny_nx = time_gt(s4_ff.ny, s4_ff.nx, s4_ff.p_ny_dx, s4_ff.p_nx_dy);
      s5_in.g_fy_fx = time_gt(s4_ff.fy, s4_ff.fx, s4_ff.p_fy_dx, s4_ff.p_fx_dy);
   end

   // stage 6: pick entry and exit, decide hit and face
   always_comb begin
      tm_type entry, leave;
      logic   lneg, egt1;
      entry = s5_ff.g_nx_ny ? s5_ff.nx : s5_ff.ny;
      leave = s5_ff.g_fy_fx ? s5_ff.fx : s5_ff.fy;
      s6_in.vld  = s5_ff.vld;
      s6_in.eden = s5_ff.g_nx_ny ? s5_ff.b.dxd : s5_ff.b.dyd;
      lneg = leave.num[OFS_W-1];
      egt1 = entry.inf ? !entry.num[OFS_W-1]
                       : entry.num > $signed({{(OFS_W-DEN_W){1'b0}}, s6_in.eden});
      s6_in.hit  = !(s5_ff.b.early || s5_ff.g_nx_fy || s5_ff.g_ny_fx || lneg || egt1);
      s6_in.einf = entry.inf;
      s6_in.enm  = entry.num;
      priority if (s5_ff.g_nx_ny) begin
         s6_in.normal = s5_ff.b.dx[CRD_W-1] ? NRM_RIGHT : NRM_LEFT;
      end else if (s5_ff.g_ny_nx) begin
         s6_in.normal = s5_ff.b.dy[CRD_W-1] ? NRM_DOWN : NRM_UP;
      end else begin
         s6_in.normal = NRM_NONE;
      end
      s6_in.ox = s5_ff.b.ox;
      s6_in.oy = s5_ff.b.oy;
      s6_in.dx = s5_ff.b.dx;
      s6_in.dy = s5_ff.b.dy;
   end

   // stage 7: displacement products
   always_comb begin
      s7_in.vld    = s6_ff.vld;
      s7_in.hit    = s6_ff.hit;
      s7_in.einf   = s6_ff.einf;
      s7_in.enm    = s6_ff.enm;
      s7_in.eden   = s6_ff.eden;
      s7_in.normal = s6_ff.normal;
      s7_in.ox     = s6_ff.ox;
      s7_in.oy     = s6_ff.oy;
      s7_in.px     = s6_ff.enm * s6_ff.dx;
      s7_in.py     = s6_ff.enm * s6_ff.dy;
   end

   // stage 8: rounded dividends (magnitude plus half the divisor)
   always_comb begin
      logic signed [OFS_W-1:0] en_abs;
      logic signed [PRD_W-1:0] px_abs, py_abs;
      en_abs = s7_ff.enm[OFS_W-1] ? -s7_ff.enm : s7_ff.enm;
      px_abs = s7_ff.px[PRD_W-1] ? -s7_ff.px : s7_ff.px;
      py_abs = s7_ff.py[PRD_W-1] ? -s7_ff.py : s7_ff.py;
      den_in   = s7_ff.eden;
      nd_ct_in = (DIV_NW'(en_abs) << TIME_FRAC_BITS) + DIV_NW'(s7_ff.eden >> 1);
      nd_cx_in = px_abs[DIV_NW-1:0] + DIV_NW'(s7_ff.eden >> 1);
      nd_cy_in = py_abs[DIV_NW-1:0] + DIV_NW'(s7_ff.eden >> 1);
      side_in.vld    = s7_ff.vld;
      side_in.hit    = s7_ff.hit;
      side_in.einf   = s7_ff.einf;
      side_in.ct_neg = s7_ff.enm[OFS_W-1];
      side_in.cx_neg = s7_ff.px[PRD_W-1];
      side_in.cy_neg = s7_ff.py[PRD_W-1];
      side_in.normal = s7_ff.normal;
      side_in.ox     = s7_ff.ox;
      side_in.oy     = s7_ff.oy;
   end

   rrsi_div u_div_ct (
      .clock(clock), .enable(adv), .dividend(nd_ct_in), .divisor(den_in),
      .quotient(q_ct), .overflow(o_ct)
   );
   rrsi_div u_div_cx (
      .clock(clock), .enable(adv), .dividend(nd_cx_in), .divisor(den_in),
      .quotient(q_cx), .overflow(o_cx)
   );
   rrsi_div u_div_cy (
      .clock(clock), .enable(adv), .dividend(nd_cy_in), .divisor(den_in),
      .quotient(q_cy), .overflow(o_cy)
   );

   // final stage A: sign and saturate the time, sign the displacements
   always_comb begin
      side_type sd;
      sd = side_ff[DIV_LAT-1];
      f1_in.vld    = sd.vld;
      f1_in.hit    = sd.hit;
      f1_in.einf   = sd.einf;
      f1_in.normal = sd.normal;
      f1_in.ox     = sd.ox;
      f1_in.oy     = sd.oy;
      if (sd.einf) begin
         f1_in.ct = OUT_MIN;
      end else if (sd.ct_neg) begin
         f1_in.ct = (o_ct || q_ct > QUO_W'(1 << (CRD_W-1))) ? OUT_MIN
                                                            : -CRD_W'(q_ct);
      end else begin
         f1_in.ct = (o_ct || q_ct > QUO_W'(OUT_MAX)) ? OUT_MAX : CRD_W'(q_ct);
      end
      f1_in.qx  = sd.cx_neg ? -$signed({1'b0, q_cx}) : $signed({1'b0, q_cx});
      f1_in.qy  = sd.cy_neg ? -$signed({1'b0, q_cy}) : $signed({1'b0, q_cy});
      f1_in.ovx = o_cx;
      f1_in.ovy = o_cy;
      f1_in.nx  = sd.cx_neg;
      f1_in.ny  = sd.cy_neg;
   end

   // final stage B: contact point, miss zeroing
   always_comb begin
      logic signed [CRD_W-1:0] cx, cy;
      if (f1_ff.einf) begin
         cx = f1_ff.ox;
         cy = f1_ff.oy;
      end else begin
         cx = f1_ff.ovx ? (f1_ff.nx ? OUT_MIN : OUT_MAX)
                        : sat_sum((QUO_W+2)'(f1_ff.ox) + (QUO_W+2)'(f1_ff.qx));
         cy = f1_ff.ovy ? (f1_ff.ny ? OUT_MIN : OUT_MAX)
                        : sat_sum((QUO_W+2)'(f1_ff.oy) + (QUO_W+2)'(f1_ff.qy));
      end
      rsp_tvalid_in = f1_ff.vld;
      if (f1_ff.hit) begin
         rsp_tdata_in = {4'b0, f1_ff.normal, cy, cx, f1_ff.ct, 1'b1};
      end else begin
         rsp_tdata_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.vld     <= 1'b0;
         s2_ff.vld     <= 1'b0;
         s3_ff.vld     <= 1'b0;
         s4_ff.vld     <= 1'b0;
         s5_ff.vld     <= 1'b0;
         s6_ff.vld     <= 1'b0;
         s7_ff.vld     <= 1'b0;
         f1_ff.vld     <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
         for (int i = 0; i < DIV_LAT; i++) begin
            side_ff[i].vld <= 1'b0;
         end
      end else if (adv) begin
         s1_ff <= s1_in;
         s2_ff <= s2_in;
         s3_ff <= s3_in;
         s4_ff <= s4_in;
         s5_ff <= s5_in;
         s6_ff <= s6_in;
         s7_ff <= s7_in;
         side_ff[0] <= side_in;
         for (int i = 1; i < DIV_LAT; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
         f1_ff         <= f1_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         rsp_tdata_ff  <= rsp_tdata_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[0] |-> rsp_tdata[RSP_W-1:1] == '0)
      else $error("miss carries a nonzero payload");

   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("input taken while output stalled");

   a_enter: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> s1_ff.vld)
      else $error("accepted transfer lost at first stage");

endmodule
`default_nettype wire

// ===== test/ray_rect_slab_intersect_checker.sv =====
// Result checker for the ray/rectangle slab test: predicts each hit record and compares.
`timescale 1ns / 1ps
module ray_rect_slab_intersect_checker (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_tvalid,
   input  wire logic                       req_tready,
   input  wire logic [rrsi_pkg::REQ_W-1:0] req_tdata,
   input  wire logic                       rsp_tvalid,
   input  wire logic                       rsp_tready,
   input  wire logic [rrsi_pkg::RSP_W-1:0] rsp_tdata,
   output int                              fail_count,
   output int                              pending_hits
);
   import rrsi_pkg::*;

   typedef struct packed {
      logic [NRM_W-1:0]        normal;
      logic signed [CRD_W-1:0] cy;
      logic signed [CRD_W-1:0] cx;
      logic signed [CRD_W-1:0] ctime;
      logic                    hit;
   } contact_t;

   // time as exact fraction; den 0 means infinity with the sign of num
   typedef struct {
      longint num;
      longint den;
   } slab_time_t;

   contact_t hit_queue[$];

   function automatic slab_time_t form_time(longint n, longint d);
      slab_time_t t;
      if (d == 0) begin
         t.num = (n > 0) ? 1 : -1;
         t.den = 0;
      end else if (d < 0) begin
         t.num = -n;
         t.den = -d;
      end else begin
         t.num = n;
         t.den = d;
      end
      return t;
   endfunction

   function automatic int order(slab_time_t a, slab_time_t b);
      longint l, r;
      if (a.den == 0 && b.den == 0) return (a.num > b.num) - (a.num < b.num);
      if (a.den == 0) return (a.num > 0) ? 1 : -1;
      if (b.den == 0) return (b.num > 0) ? -1 : 1;
      l = a.num * b.den;
      r = b.num * a.den;
      return (l > r) - (l < r);
   endfunction

   function automatic longint round_div(longint p, longint q);
      if (p >= 0) return (p + q / 2) / q;
      return -((-p + q / 2) / q);
   endfunction

   function automatic longint clamp24(longint v);
      if (v > 8388607) return 8388607;
      if (v < -8388608) return -8388608;
      return v;
   endfunction

   function automatic contact_t predict_contact(logic [REQ_W-1:0] d);
      longint ox, oy, dx, dy, rl, rt, rw, rh, ct, cx, cy;
      slab_time_t nx, fx, ny, fy, tmp, entry, leave, zero_t, one_t;
      int c;
      contact_t r;
      ox = longint'($signed(d[23:0]));
      oy = longint'($signed(d[47:24]));
      dx = longint'($signed(d[71:48]));
      dy = longint'($signed(d[95:72]));
      rl = longint'($signed(d[111:96]));
      rt = longint'($signed(d[127:112]));
      rw = longint'(d[142:128]);
      rh = longint'(d[157:143]);
      r = '0;
      nx = form_time(rl * 256 - ox, dx);
      fx = form_time((rl + rw) * 256 - ox, dx);
      ny = form_time(rt * 256 - oy, dy);
      fy = form_time((rt + rh) * 256 - oy, dy);
      // edge exactly on origin with no motion: undefined time, miss
      if (dx == 0 && (rl * 256 == ox || (rl + rw) * 256 == ox)) return r;
      if (dy == 0 && (rt * 256 == oy || (rt + rh) * 256 == oy)) return r;
      if (order(nx, fx) > 0) begin tmp = nx; nx = fx; fx = tmp; end
      if (order(ny, fy) > 0) begin tmp = ny; ny = fy; fy = tmp; end
      if (order(nx, fy) > 0 || order(ny, fx) > 0) return r;
      c = order(nx, ny);
      entry = (c > 0) ? nx : ny;
      leave = (order(fx, fy) < 0) ? fx : fy;
      zero_t.num = 0; zero_t.den = 1;
      one_t.num = 1; one_t.den = 1;
      if (order(leave, zero_t) < 0 || order(entry, one_t) > 0) return r;
      if (entry.den == 0) begin
         ct = -8388608; cx = ox; cy = oy;
      end else begin
         ct = clamp24(round_div(entry.num * 65536, entry.den));
         cx = clamp24(ox + round_div(entry.num * dx, entry.den));
         cy = clamp24(oy + round_div(entry.num * dy, entry.den));
      end
      r.hit = 1'b1;
      r.ctime = ct[23:0];
      r.cx = cx[23:0];
      r.cy = cy[23:0];
      if (c > 0) r.normal = (dx < 0) ? NRM_RIGHT : NRM_LEFT;
      else if (c < 0) r.normal = (dy < 0) ? NRM_DOWN : NRM_UP;
      else r.normal = NRM_NONE;
      return r;
   endfunction

   always @(posedge clock) begin
      contact_t want, got;
      if (reset) begin
         fail_count <= 0;
      end else begin
         if (req_tvalid && req_tready) hit_queue.push_back(predict_contact(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[76:0];
            if (hit_queue.size() == 0) begin
               if (fail_count < 10) $display("unexpected transfer %h", rsp_tdata);
               fail_count <= fail_count + 1;
            end else begin
               want = hit_queue.pop_front();
               if (got !== want || rsp_tdata[79:77] !== 3'b0) begin
                  if (fail_count < 10)
                     $display("mismatch: hit %b/%b time %h/%h x %h/%h y %h/%h nrm %0d/%0d",
                        want.hit, got.hit, want.ctime, got.ctime, want.cx, got.cx,
                        want.cy, got.cy, want.normal, got.normal);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
      pending_hits <= hit_queue.size();
   end
endmodule

// ===== test/ray_rect_slab_intersect_test.sv =====
// Testbench top: ray/rectangle stimulus, idling and the final verdict.
`timescale 1ns / 1ps
module ray_rect_slab_intersect_test;
   import rrsi_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;
   int fail_count, pending_hits;
   int cycle_count = 0;
   bit hold_off = 1'b0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   ray_rect_slab_intersect u_top (.*);

   ray_rect_slab_intersect_checker u_check (.*);

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 400000) begin
         $display("simulation failed");
         $finish;
      end
   end

   // receiver: random stall per transfer, or a long hold-off when asked
   initial begin
      int gap;
      @(posedge clock iff !reset);
      forever begin
         gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 19) : 0;
         if (gap > 0 || hold_off) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
            while (hold_off) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock iff rsp_tvalid);
      end
   end

   task automatic send_ray(logic signed [23:0] ox, oy, dx, dy,
                           logic signed [15:0] rl, rt, logic [14:0] rw, rh, int gap);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {2'b00, rh, rw, rt, rl, dy, dx, oy, ox};
      @(posedge clock iff req_tready);
   endtask

   function automatic logic [23:0] pick_coord(logic [15:0] edge_at);
      case ($urandom_range(0, 5))
         0: return 24'($urandom);
         1: return {edge_at[15:0], 8'h00};
         2: return {edge_at[15:0], 8'h00} + 24'($urandom_range(0, 4000)) - 24'd2000;
         default: return {edge_at[15:0], 8'h00} + 24'($urandom_range(0, 60000)) - 24'd30000;
      endcase
   endfunction

   function automatic logic [23:0] pick_dir();
      case ($urandom_range(0, 5))
         0: return 24'd0;
         1: return 24'($urandom);
         2: return 24'($urandom_range(0, 2000)) - 24'd1000;
         default: return 24'($urandom_range(0, 80000)) - 24'd40000;
      endcase
   endfunction

   initial begin
      logic [15:0] rl, rt;
      logic [14:0] rw, rh;
      logic [23:0] ox, oy;
      int gap;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      // directed: hits from each face, corner, inside, zero direction, extremes
      send_ray(-24'sd2560, 24'sd1280, 24'sd5120, 24'sd0, 0, 0, 10, 10, 0);
      send_ray(24'sd5120, 24'sd1280, -24'sd5120, 24'sd0, 0, 0, 10, 10, 0);
      send_ray(24'sd1280, -24'sd2560, 24'sd0, 24'sd5120, 0, 0, 10, 10, 0);
      send_ray(24'sd1280, 24'sd5120, 24'sd0, -24'sd5120, 0, 0, 10, 10, 0);
      send_ray(-24'sd256, -24'sd256, 24'sd512, 24'sd512, 0, 0, 10, 10, 0);
      send_ray(24'sd1280, 24'sd1280, 24'sd0, 24'sd0, 0, 0, 10, 10, 0);
      send_ray(24'sd0, 24'sd1280, 24'sd0, 24'sd100, 0, 0, 10, 10, 0);
      send_ray(24'sd1280, 24'sd2560, 24'sd100, 24'sd0, 0, 0, 10, 10, 0);
      send_ray(24'sd1280, 24'sd1280, 24'sd300, 24'sd7, 0, 0, 10, 10, 0);
      send_ray(-24'sd2560, 24'sd1280, 24'sd256, 24'sd0, 0, 0, 10, 10, 0);
      send_ray(24'sd1280, 24'sd1280, 24'sd3, 24'sd0, 0, 0, 0, 0, 0);
      send_ray(24'sh7FFFFF, 24'sh7FFFFF, 24'sh800000, 24'sh800000, 16'sh8000, 16'sh8000,
               15'h7FFF, 15'h7FFF, 0);
      send_ray(24'sh800000, 24'sh800000, 24'sh7FFFFF, 24'sh7FFFFF, 16'sh7FFF, 16'sh7FFF,
               15'h7FFF, 15'h7FFF, 0);
      send_ray(24'sh800000, 24'sd0, 24'sd1, 24'sd0, 16'sh8000, -16'sd1, 15'h7FFF, 2, 0);
      send_ray(24'sd0, 24'sd0, 24'sh7FFFFF, 24'sd0, 16'sh7FFF, -16'sd1, 0, 2, 0);
      send_ray(-24'sd1, 24'sd5, 24'sd1, 24'sd0, 0, 0, 5, 5, 0);
      send_ray(24'sd5, -24'sd1, 24'sd0, 24'sd1, 0, 0, 5, 5, 0);
      // drain fully, then a long receiver hold-off while the sender keeps offering
      req_tvalid <= 1'b0;
      @(posedge clock iff pending_hits == 0);
      hold_off = 1'b1;
      fork
         begin
            repeat (300) @(posedge clock);
            hold_off = 1'b0;
         end
      join_none
      for (int i = 0; i < 1350; i++) begin
         rl = 16'($urandom);
         rt = 16'($urandom);
         rw = ($urandom_range(0, 7) == 0) ? 15'($urandom) : 15'($urandom_range(0, 64));
         rh = ($urandom_range(0, 7) == 0) ? 15'($urandom) : 15'($urandom_range(0, 64));
         ox = pick_coord(rl);
         oy = pick_coord(rt);
         gap = ($urandom_range(0, 2) == 0 && i > 100) ? $urandom_range(0, 19) : 0;
         send_ray(ox, oy, pick_dir(), pick_dir(), rl, rt, rw, rh, gap);
      end
      req_tvalid <= 1'b0;
      @(posedge clock iff pending_hits == 0);
      repeat (60) @(posedge clock);
      if (fail_count == 0 && pending_hits == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end
endmodule
